// ----- hw/rtl/mlp_tanh_inference_assert.svh -----
// Assertion macros for the MLP inference block.
// Included by files that carry concurrent checks; expects clk and rst in scope.
`ifndef MLP_TANH_INFERENCE_ASSERT_SVH
`define MLP_TANH_INFERENCE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define MTI_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define MTI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MTI_ASSERT_IMPL(lbl, ante, cons, msg)
`define MTI_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/mti_pkg.sv -----
// Shared constants, types and helper functions for the MLP inference block.
// No dependencies; used by the interfaces, controller, datapath and top level.
`default_nettype none
package mti_pkg;

  // sizing
  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_LAYERS   = 4;
  localparam int WEIGHT_DEPTH = 16384;
  localparam int MAX_OUT      = 64;
  localparam int NUM_WREGS    = 4;

  localparam int DATA_W  = 16;
  localparam int NODE_W  = $clog2(MAX_WIDTH);
  localparam int WID_W   = NODE_W + 1;
  localparam int LYR_W   = $clog2(NUM_WREGS);
  localparam int LCNT_W  = 3;
  localparam int CIDX_W  = 3;
  localparam int CDATA_W = WID_W;
  localparam int AADDR_W = $clog2(MAX_LAYERS * MAX_WIDTH);
  localparam int WADDR_W = $clog2(WEIGHT_DEPTH);
  localparam int PTR_W   = 2 * WID_W + LYR_W + 1;
  localparam int ACC_W   = 2 * DATA_W + NODE_W;
  localparam int ONUM_W  = $clog2(MAX_OUT);
  localparam int OCNT_W  = ONUM_W + 1;

  // tanh interpolation
  localparam int SEG_SHIFT = 25;
  localparam int SAT_SHIFT = 30;
  localparam int TAB_W     = 15;
  localparam int LERP_W    = TAB_W + SEG_SHIFT;
  localparam logic [DATA_W-1:0] ONE_Q14 = 16'd16384;

  // op codes
  localparam logic [1:0] OP_WEIGHT = 2'd0;
  localparam logic [1:0] OP_ACT    = 2'd1;
  localparam logic [1:0] OP_RUN    = 2'd2;

  // register indexes
  localparam logic [CIDX_W-1:0] CFG_LAYERS = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_WIDTH0 = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_WIDTH1 = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_WIDTH2 = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_WIDTH3 = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LDW1,
    S_LDW2,
    S_NODE,
    S_MAC,
    S_WAIT,
    S_ORD,
    S_OLD
  } state_t;

  typedef struct packed {
    logic act_load;
    logic capture;
    logic ldw_write;
    logic run_init;
    logic node_init;
    logic mac_issue;
    logic node_next;
    logic layer_next;
    logic out_init;
    logic out_issue;
    logic out_load;
    logic out_next;
  } cmd_t;

  typedef struct packed {
    logic k_last;
    logic j_last;
    logic l_last;
    logic node_done;
    logic out_valid;
    logic o_last;
  } status_t;

  // layer width clamped to [1, MAX_WIDTH]
  function automatic logic [WID_W-1:0] eff_width(input logic [WID_W-1:0] w);
    logic [WID_W-1:0] r;
    r = w;
    if (w == '0) r = WID_W'(1);
    if (w > WID_W'(MAX_WIDTH)) r = WID_W'(MAX_WIDTH);
    return r;
  endfunction

  // layer count clamped to [2, 4]
  function automatic logic [LCNT_W-1:0] eff_layers(input logic [LCNT_W-1:0] n);
    logic [LCNT_W-1:0] r;
    r = n;
    if (n < LCNT_W'(2)) r = LCNT_W'(2);
    if (n > LCNT_W'(NUM_WREGS)) r = LCNT_W'(NUM_WREGS);
    return r;
  endfunction

  // tanh(i/8) in Q2.14, segment end points
  function automatic logic [TAB_W-1:0] tanh_point(input logic [5:0] idx);
    logic [TAB_W-1:0] r;
    case (idx)
      6'd0:  r = 15'd0;
      6'd1:  r = 15'd2037;
      6'd2:  r = 15'd4013;
      6'd3:  r = 15'd5871;
      6'd4:  r = 15'd7571;
      6'd5:  r = 15'd9087;
      6'd6:  r = 15'd10406;
      6'd7:  r = 15'd11537;
      6'd8:  r = 15'd12478;
      6'd9:  r = 15'd13260;
      6'd10: r = 15'd13898;
      6'd11: r = 15'd14416;
      6'd12: r = 15'd14830;
      6'd13: r = 15'd15161;
      6'd14: r = 15'd15423;
      6'd15: r = 15'd15630;
      6'd16: r = 15'd15795;
      6'd17: r = 15'd15925;
      6'd18: r = 15'd16024;
      6'd19: r = 15'd16100;
      6'd20: r = 15'd16165;
      6'd21: r = 15'd16213;
      6'd22: r = 15'd16250;
      6'd23: r = 15'd16280;
      6'd24: r = 15'd16303;
      6'd25: r = 15'd16321;
      6'd26: r = 15'd16335;
      6'd27: r = 15'd16346;
      6'd28: r = 15'd16354;
      6'd29: r = 15'd16361;
      6'd30: r = 15'd16366;
      6'd31: r = 15'd16370;
      6'd32: r = 15'd16373;
      default: r = 15'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/mti_if.sv -----
// Valid/ready channel interfaces for input items and result words.
// Depends on mti_pkg for field widths.
`default_nettype none
interface mti_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                op;
  logic [1:0]                src_layer;
  logic [mti_pkg::NODE_W-1:0] src_node;
  logic [mti_pkg::NODE_W-1:0] dst_node;
  logic signed [mti_pkg::DATA_W-1:0] value;

  modport source (output valid, op, src_layer, src_node, dst_node, value, input ready);
  modport sink (input valid, op, src_layer, src_node, dst_node, value, output ready);
endinterface

interface mti_out_if;
  logic                       valid;
  logic                       ready;
  logic [mti_pkg::ONUM_W-1:0] out_node;
  logic signed [mti_pkg::DATA_W-1:0] out_value;
  logic                       last;

  modport source (output valid, out_node, out_value, last, input ready);
  modport sink (input valid, out_node, out_value, last, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/mlp_tanh_inference.sv -----
// Input activation load: written as the word is taken. Weight load: capture, address
// multiply, then write. Run: per destination node, each source node on the single MAC,
// then pipeline drain and tanh; then result words, plus any wait on the result channel.
// The shared multiply-accumulate and the single read port of each store serialize these steps.
// Synchronous reset restores registers (4 layers, widths 786/16/16/10); the
// stores are not cleared and hold nothing defined until written.
`default_nettype none
`include "mlp_tanh_inference_assert.svh"
module mlp_tanh_inference (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [mti_pkg::CIDX_W-1:0]  cfg_index,
  input  wire logic [mti_pkg::CDATA_W-1:0] cfg_data,
  mti_in_if.sink                           in_ch,
  mti_out_if.source                        out_ch
);
  import mti_pkg::*;

  cmd_t    cmd;
  status_t st;
  logic    in_ready;

  assign in_ch.ready = in_ready;

  mti_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.op),
    .st       (st),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  mti_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_src_layer (in_ch.src_layer),
    .in_src_node  (in_ch.src_node),
    .in_dst_node  (in_ch.dst_node),
    .in_value     (in_ch.value),
    .cmd          (cmd),
    .st           (st),
    .out_ch       (out_ch)
  );

  // checks
  `MTI_ASSERT_NEXT(a_run_blocks, in_ch.valid && in_ch.ready && (in_ch.op == OP_RUN), !in_ch.ready, "input taken during run")
  `MTI_ASSERT_IMPL(a_out_range, out_ch.valid, ($signed(out_ch.out_value) <= 16384) && ($signed(out_ch.out_value) >= -16384), "result outside tanh range")
  `MTI_ASSERT_NEXT(a_last_gap, out_ch.valid && out_ch.ready && out_ch.last, !out_ch.valid, "word right after last")
endmodule
`default_nettype wire

// ----- hw/rtl/mti_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none
module mti_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- hw/rtl/mti_ctrl.sv -----
// Sequencer for loads, the layer sweep and result delivery.
// Depends on mti_pkg; drives datapath commands, reads datapath status.
`default_nettype none
module mti_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic [1:0]       in_op,
  input  wire mti_pkg::status_t st,
  output logic                  in_ready,
  output mti_pkg::cmd_t         cmd
);
  import mti_pkg::*;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_op)
            OP_ACT: begin
              cmd.act_load = 1'b1;
            end
            OP_WEIGHT: begin
              cmd.capture = 1'b1;
              state_next  = S_LDW1;
            end
            OP_RUN: begin
              cmd.run_init = 1'b1;
              state_next   = S_NODE;
            end
            default: ;
          endcase
        end
      end
      // address product settles
      S_LDW1: begin
        state_next = S_LDW2;
      end
      S_LDW2: begin
        cmd.ldw_write = 1'b1;
        state_next    = S_IDLE;
      end
      S_NODE: begin
        cmd.node_init = 1'b1;
        state_next    = S_MAC;
      end
      // one source node per cycle
      S_MAC: begin
        cmd.mac_issue = 1'b1;
        if (st.k_last) begin
          state_next = S_WAIT;
        end
      end
      // drain MAC and tanh pipeline
      S_WAIT: begin
        if (st.node_done) begin
          if (!st.j_last) begin
            cmd.node_next = 1'b1;
            state_next    = S_NODE;
          end else if (!st.l_last) begin
            cmd.layer_next = 1'b1;
            state_next     = S_NODE;
          end else begin
            cmd.out_init = 1'b1;
            state_next   = S_ORD;
          end
        end
      end
      // read next result once the output register is free
      S_ORD: begin
        if (!st.out_valid) begin
          cmd.out_issue = 1'b1;
          state_next    = S_OLD;
        end
      end
      S_OLD: begin
        cmd.out_load = 1'b1;
        cmd.out_next = 1'b1;
        state_next   = st.o_last ? S_IDLE : S_ORD;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ----- hw/rtl/mti_dp.sv -----
// Datapath: config registers, weight/activation stores, addressing, MAC and tanh.
// Depends on mti_pkg, mti_if and mti_ram.
`default_nettype none
module mti_dp (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [mti_pkg::CIDX_W-1:0]   cfg_index,
  input  wire logic [mti_pkg::CDATA_W-1:0]  cfg_data,
  input  wire logic [1:0]                   in_src_layer,
  input  wire logic [mti_pkg::NODE_W-1:0]   in_src_node,
  input  wire logic [mti_pkg::NODE_W-1:0]   in_dst_node,
  input  wire logic [mti_pkg::DATA_W-1:0]   in_value,
  input  wire mti_pkg::cmd_t                cmd,
  output mti_pkg::status_t                  st,
  mti_out_if.source                         out_ch
);
  import mti_pkg::*;

  // configuration
  logic [LCNT_W-1:0] layer_count;
  logic [WID_W-1:0]  width_reg [NUM_WREGS];
  logic [WID_W-1:0]  weff [NUM_WREGS];
  logic [LCNT_W-1:0] nl;
  logic [LCNT_W-1:0] nl_m1;

  always_ff @(posedge clk) begin
    if (rst) begin
      layer_count  <= 3'd4;
      width_reg[0] <= 11'd786;
      width_reg[1] <= 11'd16;
      width_reg[2] <= 11'd16;
      width_reg[3] <= 11'd10;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LAYERS: layer_count  <= cfg_data[LCNT_W-1:0];
        CFG_WIDTH0: width_reg[0] <= cfg_data;
        CFG_WIDTH1: width_reg[1] <= cfg_data;
        CFG_WIDTH2: width_reg[2] <= cfg_data;
        CFG_WIDTH3: width_reg[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int m = 0; m < NUM_WREGS; m++) begin
      weff[m] = eff_width(width_reg[m]);
    end
  end
  assign nl    = eff_layers(layer_count);
  assign nl_m1 = nl - LCNT_W'(1);

  // weight block bases, one register stage behind the config
  logic [2*WID_W-1:0] pair [NUM_WREGS-1];
  logic [PTR_W-1:0]   base [NUM_WREGS];

  always_comb begin
    base[0] = '0;
    for (int m = 1; m < NUM_WREGS; m++) begin
      base[m] = base[m-1] + PTR_W'(pair[m-1]);
    end
  end

  always_ff @(posedge clk) begin
    for (int m = 0; m < NUM_WREGS - 1; m++) begin
      pair[m] <= (2*WID_W)'(weff[m]) * (2*WID_W)'(weff[m+1]);
    end
  end

  // weight load: capture, multiply, then check and write
  logic [LYR_W-1:0]  lsl;
  logic [NODE_W-1:0] lsn, ldn;
  logic [DATA_W-1:0] lval;
  logic [PTR_W-1:0]  ld_prod;
  logic              ld_ok;
  logic [PTR_W-1:0]  ld_addr;
  logic              w_we;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      lsl  <= in_src_layer;
      lsn  <= in_src_node;
      ldn  <= in_dst_node;
      lval <= in_value;
    end
    ld_prod <= PTR_W'(lsn) * PTR_W'(weff[lsl + LYR_W'(1)]);
    ld_ok   <= ((LCNT_W'(lsl) + LCNT_W'(1)) < nl) &&
               ({1'b0, lsn} < weff[lsl]) &&
               ({1'b0, ldn} < weff[lsl + LYR_W'(1)]);
  end

  assign ld_addr = base[lsl] + ld_prod + PTR_W'(ldn);
  assign w_we    = cmd.ldw_write && ld_ok && (ld_addr < PTR_W'(WEIGHT_DEPTH));

  // sweep counters
  logic [LYR_W-1:0]  lyr;
  logic [NODE_W-1:0] jn, kn;
  logic [PTR_W-1:0]  wptr;
  logic [ONUM_W-1:0] on;
  logic [WID_W-1:0]  ws, wd;

  assign ws = weff[lyr];
  assign wd = weff[lyr + LYR_W'(1)];

  always_ff @(posedge clk) begin
    if (cmd.run_init) begin
      lyr <= '0;
      jn  <= '0;
    end else if (cmd.layer_next) begin
      lyr <= lyr + LYR_W'(1);
      jn  <= '0;
    end else if (cmd.node_next) begin
      jn <= jn + NODE_W'(1);
    end
    if (cmd.node_init) begin
      kn   <= '0;
      wptr <= base[lyr] + PTR_W'(jn);
    end else if (cmd.mac_issue) begin
      kn   <= kn + NODE_W'(1);
      wptr <= wptr + PTR_W'(wd);
    end
    if (cmd.out_init) begin
      on <= '0;
    end else if (cmd.out_next) begin
      on <= on + ONUM_W'(1);
    end
  end

  // stores
  logic [DATA_W-1:0]  w_rd, a_rd;
  logic               a_we;
  logic [AADDR_W-1:0] a_waddr, a_raddr;
  logic [DATA_W-1:0]  a_wdata;
  logic               act_ok;
  logic               t2_go;
  logic [DATA_W-1:0]  tanh_val;

  assign act_ok  = cmd.act_load && ({1'b0, in_src_node} < weff[0]);
  assign a_we    = act_ok || t2_go;
  assign a_waddr = t2_go ? {lyr + LYR_W'(1), jn} : {LYR_W'(0), in_src_node};
  assign a_wdata = t2_go ? tanh_val : in_value;
  assign a_raddr = cmd.out_issue ? {nl_m1[LYR_W-1:0], NODE_W'(on)} : {lyr, kn};

  mti_ram #(.WIDTH(DATA_W), .DEPTH(WEIGHT_DEPTH)) u_wram (
    .clk   (clk),
    .we    (w_we),
    .waddr (ld_addr[WADDR_W-1:0]),
    .wdata (lval),
    .raddr (wptr[WADDR_W-1:0]),
    .rdata (w_rd)
  );

  mti_ram #(.WIDTH(DATA_W), .DEPTH(MAX_LAYERS * MAX_WIDTH)) u_aram (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (a_wdata),
    .raddr (a_raddr),
    .rdata (a_rd)
  );

  // MAC pipeline: read, multiply, accumulate
  logic s1_v, s1_last, s1_oor, s2_v, s2_last, s3_go, t1_go;
  logic signed [2*DATA_W-1:0] prod;
  logic signed [ACC_W-1:0]    acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v    <= 1'b0;
      s1_last <= 1'b0;
      s2_v    <= 1'b0;
      s2_last <= 1'b0;
      s3_go   <= 1'b0;
      t1_go   <= 1'b0;
      t2_go   <= 1'b0;
    end else begin
      s1_v    <= cmd.mac_issue;
      s1_last <= cmd.mac_issue && st.k_last;
      s2_v    <= s1_v;
      s2_last <= s1_v && s1_last;
      s3_go   <= s2_v && s2_last;
      t1_go   <= s3_go;
      t2_go   <= t1_go;
    end
  end

  always_ff @(posedge clk) begin
    s1_oor <= wptr >= PTR_W'(WEIGHT_DEPTH);
    prod   <= $signed(a_rd) * $signed(s1_oor ? DATA_W'(0) : w_rd);
    if (cmd.node_init) begin
      acc <= '0;
    end else if (s2_v) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // tanh: magnitude and segment, interpolate, restore sign
  logic [ACC_W-1:0]           mag;
  logic                       neg1, sat1, neg2, sat2;
  logic [4:0]                 seg1, seg2;
  logic [SEG_SHIFT-1:0]       frac1;
  logic [TAB_W-1:0]           diff;
  logic [LERP_W-1:0]          lerp2;
  logic [DATA_W-1:0]          yabs;

  assign mag  = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
  assign diff = tanh_point({1'b0, seg1} + 6'd1) - tanh_point({1'b0, seg1});

  always_ff @(posedge clk) begin
    neg1  <= acc[ACC_W-1];
    sat1  <= |mag[ACC_W-1:SAT_SHIFT];
    seg1  <= mag[SAT_SHIFT-1:SEG_SHIFT];
    frac1 <= mag[SEG_SHIFT-1:0];
    neg2  <= neg1;
    sat2  <= sat1;
    seg2  <= seg1;
    lerp2 <= LERP_W'(diff) * LERP_W'(frac1) + (LERP_W'(1) << (SEG_SHIFT - 1));
  end

  assign yabs     = sat2 ? ONE_Q14
                         : {1'b0, tanh_point({1'b0, seg2}) + lerp2[LERP_W-1:SEG_SHIFT]};
  assign tanh_val = neg2 ? DATA_W'(-yabs) : yabs;

  // result register
  logic [OCNT_W-1:0] n_out;
  logic              o_last;
  logic              o_valid;

  assign n_out  = (weff[nl_m1[LYR_W-1:0]] > WID_W'(MAX_OUT)) ? OCNT_W'(MAX_OUT)
                                                          : weff[nl_m1[LYR_W-1:0]][OCNT_W-1:0];
  assign o_last = {1'b0, on} == (n_out - OCNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (cmd.out_load) begin
      o_valid <= 1'b1;
    end else if (out_ch.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_ch.out_node  <= on;
      out_ch.out_value <= a_rd;
      out_ch.last      <= o_last;
    end
  end

  assign out_ch.valid = o_valid;

  // status
  assign st.k_last    = {1'b0, kn} == (ws - WID_W'(1));
  assign st.j_last    = {1'b0, jn} == (wd - WID_W'(1));
  assign st.l_last    = (LCNT_W'(lyr) + LCNT_W'(2)) == nl;
  assign st.node_done = t2_go;
  assign st.out_valid = o_valid;
  assign st.o_last    = o_last;
endmodule
`default_nettype wire

// ----- verif/mlp_tanh_inference_chk.sv -----
// Checker for mlp_tanh_inference: watches the config port and both word channels,
// predicts each forward pass and compares every result word in order.
// Depends on mti_pkg and the channel interfaces in mti_if.sv.
`timescale 1ns / 100ps
module mlp_tanh_inference_chk (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [mti_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [mti_pkg::CDATA_W-1:0] cfg_data,
  mti_in_if                           in_ch,
  mti_out_if                          out_ch,
  output int                          errors,
  output int                          pending
);
  import mti_pkg::*;

  typedef struct packed {
    logic [ONUM_W-1:0] node;
    logic [DATA_W-1:0] val;
    logic              last;
  } node_word_t;

  // tanh(i/8) in Q2.14
  localparam int TANH_PT [33] = '{
    0, 2037, 4013, 5871, 7571, 9087, 10406, 11537,
    12478, 13260, 13898, 14416, 14830, 15161, 15423, 15630,
    15795, 15925, 16024, 16100, 16165, 16213, 16250, 16280,
    16303, 16321, 16335, 16346, 16354, 16361, 16366, 16370,
    16373
  };

  node_word_t        pass_q[$];
  logic [DATA_W-1:0] act_mem [MAX_LAYERS*MAX_WIDTH];
  logic [DATA_W-1:0] wgt_mem [WEIGHT_DEPTH];
  logic [LCNT_W-1:0] layers_raw;
  logic [WID_W-1:0]  width_raw [NUM_WREGS];

  initial errors = 0;

  function automatic int used_layers();
    int n;
    n = layers_raw;
    if (n < 2) n = 2;
    if (n > NUM_WREGS) n = NUM_WREGS;
    return n;
  endfunction

  function automatic int used_width(input int l);
    int w;
    w = width_raw[l];
    if (w < 1) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  function automatic longint layer_base(input int l);
    longint b;
    b = 0;
    for (int m = 0; m < l; m++) b += used_width(m) * used_width(m + 1);
    return b;
  endfunction

  // piecewise-linear tanh of a Q.28 sum, result Q2.14
  function automatic logic [DATA_W-1:0] tanh_q14(input longint x);
    longint mag, frac;
    int     seg, y;
    mag = (x < 0) ? -x : x;
    if (mag >= (longint'(4) << 28)) begin
      y = 16384;
    end else begin
      seg  = int'(mag >>> SEG_SHIFT);
      frac = mag & ((longint'(1) << SEG_SHIFT) - 1);
      y = TANH_PT[seg] + int'((longint'(TANH_PT[seg+1] - TANH_PT[seg]) * frac
          + (longint'(1) << (SEG_SHIFT - 1))) >>> SEG_SHIFT);
    end
    if (x < 0) y = -y;
    return DATA_W'(y);
  endfunction

  // sweep all layers and queue the final-layer words, at most MAX_OUT of them
  task automatic forward_pass();
    int         nl, ws, wd, nout, w;
    longint     base, addr, acc;
    node_word_t nw;
    nl = used_layers();
    for (int l = 0; l + 1 < nl; l++) begin
      ws = used_width(l);
      wd = used_width(l + 1);
      base = layer_base(l);
      for (int j = 0; j < wd; j++) begin
        acc = 0;
        for (int k = 0; k < ws; k++) begin
          addr = base + longint'(k) * wd + j;
          w = (addr < WEIGHT_DEPTH) ? int'($signed(wgt_mem[addr])) : 0;
          acc += longint'($signed(act_mem[l*MAX_WIDTH + k])) * w;
        end
        act_mem[(l+1)*MAX_WIDTH + j] = tanh_q14(acc);
      end
    end
    nout = used_width(nl - 1);
    if (nout > MAX_OUT) nout = MAX_OUT;
    for (int j = 0; j < nout; j++) begin
      nw = '{node: ONUM_W'(j), val: act_mem[(nl-1)*MAX_WIDTH + j], last: (j + 1 == nout)};
      pass_q = {pass_q, nw};
    end
  endtask

  // weight load, dropped when out of range
  task automatic store_weight(input int sl, input int sn, input int dn,
                              input logic [DATA_W-1:0] v);
    longint addr;
    if (sl + 1 >= used_layers()) return;
    if (sn >= used_width(sl) || dn >= used_width(sl + 1)) return;
    addr = layer_base(sl) + longint'(sn) * used_width(sl + 1) + dn;
    if (addr < WEIGHT_DEPTH) wgt_mem[addr] = v;
  endtask

  always @(posedge clk) begin : monitor
    node_word_t exp_w;
    if (rst) begin
      layers_raw   = 3'd4;
      width_raw[0] = 11'd786;
      width_raw[1] = 11'd16;
      width_raw[2] = 11'd16;
      width_raw[3] = 11'd10;
      pass_q.delete();
    end else begin
      // config mirror
      if (cfg_we) begin
        case (cfg_index)
          CFG_LAYERS: layers_raw   = cfg_data[LCNT_W-1:0];
          CFG_WIDTH0: width_raw[0] = cfg_data;
          CFG_WIDTH1: width_raw[1] = cfg_data;
          CFG_WIDTH2: width_raw[2] = cfg_data;
          CFG_WIDTH3: width_raw[3] = cfg_data;
          default: ;
        endcase
      end
      // accepted input word
      if (in_ch.valid && in_ch.ready) begin
        case (in_ch.op)
          OP_WEIGHT: store_weight(in_ch.src_layer, in_ch.src_node, in_ch.dst_node,
                                  in_ch.value);
          OP_ACT:    if (in_ch.src_node < used_width(0)) act_mem[in_ch.src_node] = in_ch.value;
          OP_RUN:    forward_pass();
          default: ;
        endcase
      end
      // accepted result word
      if (out_ch.valid && out_ch.ready) begin
        if (pass_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word node %0d value %0d last %0b", $time,
                   out_ch.out_node, out_ch.out_value, out_ch.last);
        end else begin
          exp_w = pass_q.pop_front();
          if (out_ch.out_node !== exp_w.node) begin
            errors++;
            $display("%0t: out_node expected %0d actual %0d", $time, exp_w.node,
                     out_ch.out_node);
          end
          if (out_ch.out_value !== exp_w.val) begin
            errors++;
            $display("%0t: out_value (node %0d) expected %0d actual %0d", $time,
                     exp_w.node, $signed(exp_w.val), out_ch.out_value);
          end
          if (out_ch.last !== exp_w.last) begin
            errors++;
            $display("%0t: last (node %0d) expected %0b actual %0b", $time, exp_w.node,
                     exp_w.last, out_ch.last);
          end
        end
      end
    end
    pending <= pass_q.size();
  end
endmodule

// ----- verif/mlp_tanh_inference_tb.sv -----
// Top of the mlp_tanh_inference testbench: clock, reset, config writes and input
// words, with random stalls on both channels. Depends on mti_pkg, mti_if.sv and the checker.
`timescale 1ns / 100ps
module mlp_tanh_inference_tb;
  import mti_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  // op code with no function
  localparam logic [1:0] OP_SPARE = 2'd3;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [CIDX_W-1:0]  cfg_index = '0;
  logic [CDATA_W-1:0] cfg_data = '0;
  logic               calm = 1'b0;
  int                 errors, pending, cycles = 0;
  int                 nl_cur, wd_cur [NUM_WREGS];

  mti_in_if  in_ch ();
  mti_out_if out_ch ();

  mlp_tanh_inference DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  mlp_tanh_inference_chk chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch), .errors(errors), .pending(pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // timeout
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("mlp_tanh_inference test failed");
      $finish;
    end
  end

  // result-side stalls
  always @(posedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else out_ch.ready <= calm || ($urandom_range(99) >= 20);
  end

  function automatic int clampw(input int w);
    return (w < 1) ? 1 : (w > MAX_WIDTH) ? MAX_WIDTH : w;
  endfunction

  // one input word, held until accepted
  task automatic send(input logic [1:0] op, input int sl, input int sn, input int dn,
                      input int v);
    if (!calm && $urandom_range(99) < 20) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.op        <= op;
    in_ch.src_layer <= sl[1:0];
    in_ch.src_node  <= sn[NODE_W-1:0];
    in_ch.dst_node  <= dn[NODE_W-1:0];
    in_ch.value     <= v[DATA_W-1:0];
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // stop sending and let every result word arrive
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic cfg_set(input int lc, input int w0, input int w1, input int w2,
                         input int w3);
    int vals [5];
    vals = '{lc, w0, w1, w2, w3};
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CIDX_W'(i);
      cfg_data  <= CDATA_W'(vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    nl_cur = (lc % 8 < 2) ? 2 : (lc % 8 > NUM_WREGS) ? NUM_WREGS : lc % 8;
    for (int i = 0; i < NUM_WREGS; i++) wd_cur[i] = clampw(vals[i+1] % 2048);
  endtask

  // fill every input activation and every weight that a reported result depends on;
  // final-layer nodes past the reported ones are never read back
  task automatic load_all();
    int dmax;
    for (int k = 0; k < wd_cur[0]; k++)
      send(OP_ACT, $urandom_range(3), k, $urandom_range(1023), $urandom);
    for (int l = 0; l + 1 < nl_cur; l++) begin
      dmax = wd_cur[l+1];
      if (l + 2 == nl_cur && dmax > MAX_OUT) dmax = MAX_OUT;
      for (int s = 0; s < wd_cur[l]; s++)
        for (int d = 0; d < dmax; d++)
          send(OP_WEIGHT, l, s, d, $urandom);
    end
  endtask

  task automatic random_words(input int n, input int quiet);
    int pick, sl;
    for (int i = 0; i < n; i++) begin
      calm = (i < quiet);
      if (i == n / 2) drain();
      pick = $urandom_range(99);
      sl = $urandom_range(nl_cur - 2);
      if (pick < 15)
        send(OP_RUN, $urandom_range(3), $urandom_range(1023), $urandom_range(1023), $urandom);
      else if (pick < 50)
        send(OP_WEIGHT, sl, $urandom_range(wd_cur[sl] - 1), $urandom_range(wd_cur[sl+1] - 1),
             $urandom);
      else if (pick < 75)
        send(OP_ACT, $urandom_range(3), $urandom_range(wd_cur[0] - 1), $urandom_range(1023),
             $urandom);
      else if (pick < 85)
        send(OP_WEIGHT, $urandom_range(3), $urandom_range(1023), $urandom_range(1023), $urandom);
      else if (pick < 92)
        send(OP_ACT, $urandom_range(3), $urandom_range(1023), $urandom_range(1023), $urandom);
      else if (pick < 97)
        send(OP_SPARE, $urandom_range(3), $urandom_range(1023), $urandom_range(1023), $urandom);
      else
        send(OP_WEIGHT, nl_cur - 1, 0, 0, $urandom);
    end
    calm = 1'b0;
  endtask

  task automatic phase(input int lc, input int w0, input int w1, input int w2, input int w3,
                       input int n, input int quiet);
    drain();
    cfg_set(lc, w0, w1, w2, w3);
    load_all();
    random_words(n, quiet);
  endtask

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.op        = OP_WEIGHT;
    in_ch.src_layer = '0;
    in_ch.src_node  = '0;
    in_ch.dst_node  = '0;
    in_ch.value     = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: small 4-layer net, extreme values and ignored words
    cfg_set(4, 3, 2, 4, 2);
    load_all();
    send(OP_ACT, 0, 0, 0, 32767);
    send(OP_ACT, 0, 1, 0, -32768);
    send(OP_ACT, 0, 2, 0, 0);
    send(OP_WEIGHT, 0, 0, 0, 32767);
    send(OP_WEIGHT, 0, 1, 1, -32768);
    send(OP_RUN, 3, 1023, 1023, -1);
    send(OP_WEIGHT, 3, 0, 0, 1234);       // source layer is the output layer
    send(OP_WEIGHT, 1, 2, 0, 1234);       // source node past layer width
    send(OP_WEIGHT, 1, 0, 4, 1234);       // destination node past next width
    send(OP_ACT, 3, 1023, 1023, 777);     // input node past width
    send(OP_SPARE, 3, 1023, 1023, 32767); // unknown op
    send(OP_RUN, 0, 0, 0, 0);
    for (int k = 0; k < 3; k++) send(OP_ACT, 0, k, 0, (k == 1) ? 32767 : -32768);
    send(OP_RUN, 0, 0, 0, 0);
    random_words(60, 30);

    // register values out of range; widest output layer, only 64 nodes reported
    phase(0, 0, 2047, 5, 5, 20, 0);
    phase(7, 2, 3, 2, 3, 30, 0);
    phase(3, 4, 3, 2, 9, 20, 10);

    drain();
    if (errors == 0) begin
      $display("mlp_tanh_inference test passed");
    end else begin
      $display("mlp_tanh_inference test failed");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/mti_pkg.sv
hw/rtl/mti_if.sv
hw/rtl/mti_ram.sv
hw/rtl/mti_ctrl.sv
hw/rtl/mti_dp.sv
hw/rtl/mlp_tanh_inference.sv
verif/mlp_tanh_inference_chk.sv
verif/mlp_tanh_inference_tb.sv
